// ----- rtl/box_blur_3x3_edge_average_assert.svh -----
// Assertion macros shared by the checker of the 3x3 box blur.
// Needs no package; each macro takes a clock, a disable term and two expressions.
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bb3: check failed one cycle after its trigger");

// The consequent must hold in the same cycle as the antecedent.
`define BB3_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bb3: check failed in the cycle of its trigger");

`endif

// ----- rtl/bb3_pkg.sv -----
// Shared types, constants and helper functions of the 3x3 box blur.
// Used by every other file of the block but the assertion macro header; depends on nothing.
package bb3_pkg;

   // Field widths.
   localparam int CFG_W     = 11;
   localparam int CH_W      = 8;
   localparam int NUM_CH    = 3;
   localparam int PIX_W     = NUM_CH * CH_W;
   localparam int COORD_W   = 10;

   // Channel positions inside a packed pixel.
   localparam int CH_RED    = 2;
   localparam int CH_GREEN  = 1;
   localparam int CH_BLUE   = 0;

   // Frame geometry defaults.
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int DIM_RESET      = 1024;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   // Averaging arithmetic: column sums of three, totals of nine, and a
   // reciprocal multiply that is exact for totals below 4096 and divisors up to 9.
   localparam int COLSUM_W    = 10;
   localparam int SUM_W       = 12;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 17;
   localparam int PROD_W      = SUM_W + RECIP_W;

   // Result queue depth; it also bounds the results in flight.
   localparam int FIFO_DEPTH  = 8;

   typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_type;

   // Window indexed [column][row]: column 0 is the oldest, row 0 the oldest.
   typedef pixel_type [2:0][2:0] window_type;

   typedef struct packed {
      logic [CH_W-1:0] red_in;
      logic [CH_W-1:0] green_in;
      logic [CH_W-1:0] blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic [CH_W-1:0]    red_out;
      logic [CH_W-1:0]    green_out;
      logic [CH_W-1:0]    blue_out;
      logic               run_end;
   } rsp_payload_type;

   // One averaging job handed from the window stage to the arithmetic pipe.
   typedef struct packed {
      logic               valid;
      logic [2:0]         row_mask;
      logic [2:0]         col_mask;
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic               run_end;
   } avg_cmd_type;

   // Number of set bits in a three bit mask.
   function automatic logic [1:0] ones3(input logic [2:0] m);
      ones3 = {1'b0, m[0]} + {1'b0, m[1]} + {1'b0, m[2]};
   endfunction

   // Scaled reciprocal of the neighbor count, rounded up.
   function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] nrows,
                                                    input logic [1:0] ncols);
      logic [3:0] n;
      n = {2'b00, nrows} * {2'b00, ncols};
      case (n)
         4'd2:    recip_of = RECIP_W'(32768);
         4'd3:    recip_of = RECIP_W'(21846);
         4'd4:    recip_of = RECIP_W'(16384);
         4'd6:    recip_of = RECIP_W'(10923);
         4'd9:    recip_of = RECIP_W'(7282);
         default: recip_of = RECIP_W'(65536);
      endcase
   endfunction

endpackage

// ----- rtl/bb3_if.sv -----
// Valid/ready channel interfaces for the request and result streams.
// Depends on bb3_pkg for the payload types.
interface bb3_req_if import bb3_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bb3_rsp_if import bb3_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/bb3_line_mem.sv -----
// Line store: one synchronous memory with registered read data and
// same-cycle write-to-read forwarding. Depends on bb3_pkg for its parameter defaults.
module bb3_line_mem import bb3_pkg::*; #(
   parameter int DEPTH  = MAX_WIDTH_DEF,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 2 * PIX_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_q_ff;
   logic [DATA_W-1:0] fwd_data_ff;
   logic              fwd_hit_ff;
   logic              fwd_hit_in;

   // Memory array: read returns the old contents on an address collision.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff     <= mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // A read that hits the entry written in the same cycle takes the new data.
   always_comb begin
      fwd_hit_in = fwd_hit_ff;
      if (rd_en) begin
         fwd_hit_in = wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_q_ff;

endmodule

// ----- rtl/bb3_average.sv -----
// Averaging pipe: masked column sums, masked total, reciprocal multiply.
// Depends on bb3_pkg for the window, job and result types.
module bb3_average import bb3_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  avg_cmd_type     cmd,
   input  window_type      win,
   output logic            res_valid,
   output rsp_payload_type res
);

   typedef struct packed {
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic               run_end;
   } meta_type;

   logic [2:0][NUM_CH-1:0][COLSUM_W-1:0] p1_sum_ff, p1_sum_in;
   logic [2:0]                           p1_cmask_ff;
   logic [RECIP_W-1:0]                   p1_recip_ff, p1_recip_in;
   meta_type                             p1_meta_ff;
   logic                                 p1_valid_ff;

   logic [NUM_CH-1:0][SUM_W-1:0]         p2_tot_ff, p2_tot_in;
   logic [RECIP_W-1:0]                   p2_recip_ff;
   meta_type                             p2_meta_ff;
   logic                                 p2_valid_ff;

   logic [NUM_CH-1:0][PROD_W-1:0]        p3_prod_ff, p3_prod_in;
   meta_type                             p3_meta_ff;
   logic                                 p3_valid_ff;

   // First stage: per column, add the rows that lie inside the frame.
   always_comb begin
      logic [COLSUM_W-1:0] acc;
      for (int k = 0; k < 3; k++) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            acc = '0;
            for (int m = 0; m < 3; m++) begin
               if (cmd.row_mask[m]) begin
                  acc = acc + COLSUM_W'(win[k][m][ch]);
               end
            end
            p1_sum_in[k][ch] = acc;
         end
      end
      p1_recip_in = recip_of(ones3(cmd.row_mask), ones3(cmd.col_mask));
   end

   // Second stage: add the columns that lie inside the frame.
   always_comb begin
      logic [SUM_W-1:0] acc;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         acc = '0;
         for (int k = 0; k < 3; k++) begin
            if (p1_cmask_ff[k]) begin
               acc = acc + SUM_W'(p1_sum_ff[k][ch]);
            end
         end
         p2_tot_in[ch] = acc;
      end
   end

   // Third stage: divide by the neighbor count through its reciprocal.
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         p3_prod_in[ch] = PROD_W'(p2_tot_ff[ch]) * PROD_W'(p2_recip_ff);
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      p1_sum_ff   <= p1_sum_in;
      p1_cmask_ff <= cmd.col_mask;
      p1_recip_ff <= p1_recip_in;
      p1_meta_ff  <= '{out_row: cmd.out_row, out_col: cmd.out_col,
                       run_end: cmd.run_end};
      p2_tot_ff   <= p2_tot_in;
      p2_recip_ff <= p1_recip_ff;
      p2_meta_ff  <= p1_meta_ff;
      p3_prod_ff  <= p3_prod_in;
      p3_meta_ff  <= p2_meta_ff;
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   assign res_valid     = p3_valid_ff;
   assign res.out_row   = p3_meta_ff.out_row;
   assign res.out_col   = p3_meta_ff.out_col;
   assign res.run_end   = p3_meta_ff.run_end;
   assign res.red_out   = p3_prod_ff[CH_RED][RECIP_SHIFT +: CH_W];
   assign res.green_out = p3_prod_ff[CH_GREEN][RECIP_SHIFT +: CH_W];
   assign res.blue_out  = p3_prod_ff[CH_BLUE][RECIP_SHIFT +: CH_W];

endmodule

// ----- rtl/bb3_rsp_fifo.sv -----
// Result queue between the averaging pipe and the result channel.
// Depends on bb3_pkg for the result type and the default depth.
module bb3_rsp_fifo import bb3_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  rsp_payload_type wr_data,
   input  logic            rd_en,
   output logic            rd_valid,
   output rsp_payload_type rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_payload_type  slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign pop      = rd_en && rd_valid;

   // Storage; the issue credit keeps writes from overrunning the queue.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({wr_en, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/box_blur_3x3_edge_average.sv -----
// Top level of the streaming 3x3 box blur with edge-aware averaging.
// Depends on bb3_pkg, bb3_if, bb3_line_mem, bb3_average and bb3_rsp_fifo.
//
//   channel   direction   handshake           payload
//   req_bus   in          valid / ready       red_in, green_in, blue_in
//   rsp_bus   out         valid / ready       out_row, out_col, rgb out, run_end
//   csr_*     in          csr_wr_en only      csr_index, csr_wr_data
//
// One request per clock while no earlier results wait to issue; a request at a row end or
// on the last row causes up to two results and the last of the frame up to four, so the
// single-issue pipe holds the next request until they are issued. A first result passes
// stage one, stage two, the averaging pipe and the result queue before it is offered.
// Reset is synchronous; the line store is not cleared and needs no sweep.
// A stalled result channel fills the eight-entry result queue and then holds requests.
module box_blur_3x3_edge_average import bb3_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wr_data,
   bb3_req_if.sink              req_bus,
   bb3_rsp_if.source            rsp_bus
);

   localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WEXT_W   = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
   localparam int HEXT_W   = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;
   localparam int W_RST    = ((DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET) - 1;
   localparam int H_RST    = ((DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET) - 1;
   localparam int CREDIT_W = $clog2(FIFO_DEPTH + 1);

   // Frame geometry, kept as last column and last row.
   logic [COL_W-1:0]    width_last_ff, width_last_in;
   logic [ROW_W-1:0]    height_last_ff, height_last_in;
   logic                cfg_hit;
   logic [WEXT_W-1:0]   w_ext, w_clamp;
   logic [HEXT_W-1:0]   h_ext, h_clamp;

   // Position of the next request.
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                req_fire;

   // Stage one: request waiting for its line store column.
   logic                s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]    s1_col_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   pixel_type           s1_pix_ff;
   logic                s1_adv;
   logic [2*PIX_W-1:0]  rd_data;
   pixel_type           col_top, col_mid;

   // Sliding 3x3 window.
   window_type          win_ff, win_in;

   // Stage two: results still to be issued for the request in the window.
   logic [3:0]          pend_ff, pend_in, pend_new, pick, pend_rest;
   logic [COL_W-1:0]    s2_col_ff;
   logic [ROW_W-1:0]    s2_row_ff;
   logic                s2_rge1_ff, s2_rge2_ff, s2_cge1_ff, s2_cge2_ff;
   logic                s2_free, issue;
   logic [1:0]          sel;
   logic [ROW_W-1:0]    i_row;
   logic [COL_W-1:0]    j_col;
   logic [ROW_W+COORD_W-1:0] row_ext;
   logic [COL_W+COORD_W-1:0] col_ext;
   avg_cmd_type         cmd;

   // Result path.
   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic                res_valid;
   rsp_payload_type     res;
   logic                pop;

   // Configuration writes: clamp the dimension and restart the frame.
   always_comb begin
      w_ext          = WEXT_W'(csr_wr_data);
      h_ext          = HEXT_W'(csr_wr_data);
      w_clamp        = (w_ext == '0) ? WEXT_W'(1) :
                       (w_ext > WEXT_W'(MAX_WIDTH)) ? WEXT_W'(MAX_WIDTH) : w_ext;
      h_clamp        = (h_ext == '0) ? HEXT_W'(1) :
                       (h_ext > HEXT_W'(MAX_HEIGHT)) ? HEXT_W'(MAX_HEIGHT) : h_ext;
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      cfg_hit        = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               width_last_in = COL_W'(w_clamp - WEXT_W'(1));
               cfg_hit       = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               height_last_in = ROW_W'(h_clamp - HEXT_W'(1));
               cfg_hit        = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   // Raster counters advance on each accepted request.
   assign req_fire = req_bus.valid && req_bus.ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         if (col_ff == width_last_ff) begin
            col_in = '0;
            row_in = (row_ff == height_last_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Line store: each entry holds the two previous rows of its column.
   bb3_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W),
      .DATA_W (2 * PIX_W)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data ({col_mid, s1_pix_ff})
   );

   assign col_top = rd_data[2*PIX_W-1:PIX_W];
   assign col_mid = rd_data[PIX_W-1:0];

   // Stage one hands over when stage two is free or finishing.
   assign s1_adv        = s1_valid_ff && s2_free;
   assign req_bus.ready = !s1_valid_ff || s2_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Window shift: the new column is the two stored rows plus the request.
   always_comb begin
      win_in = win_ff;
      if (s1_adv) begin
         win_in[0]    = win_ff[1];
         win_in[1]    = win_ff[2];
         win_in[2][0] = col_top;
         win_in[2][1] = col_mid;
         win_in[2][2] = s1_pix_ff;
      end
   end

   // Results due: previous row and, on the last row, this row; previous
   // column and, on the last column, this column. Bit order is raster order.
   always_comb begin
      logic r_ge1, r_last, c_ge1, c_last;
      r_ge1    = (s1_row_ff != '0);
      r_last   = (s1_row_ff == height_last_ff);
      c_ge1    = (s1_col_ff != '0);
      c_last   = (s1_col_ff == width_last_ff);
      pend_new = {r_last & c_last, r_last & c_ge1, r_ge1 & c_last, r_ge1 & c_ge1};
   end

   // Issue the lowest pending result when the result queue has room.
   assign pick      = pend_ff & (~pend_ff + 4'd1);
   assign pend_rest = pend_ff & ~pick;
   assign sel       = {pick[2] | pick[3], pick[1] | pick[3]};
   assign issue     = (pend_ff != '0) && (credit_ff < CREDIT_W'(FIFO_DEPTH));
   assign s2_free   = (pend_ff == '0) || (issue && (pend_rest == '0));

   always_comb begin
      pend_in = pend_ff;
      if (s1_adv) begin
         pend_in = pend_new;
      end else if (issue) begin
         pend_in = pend_rest;
      end
   end

   // Averaging job: pick the window rows and columns inside the frame.
   always_comb begin
      i_row        = sel[1] ? s2_row_ff : s2_row_ff - ROW_W'(1);
      j_col        = sel[0] ? s2_col_ff : s2_col_ff - COL_W'(1);
      row_ext      = {{COORD_W{1'b0}}, i_row};
      col_ext      = {{COORD_W{1'b0}}, j_col};
      cmd.valid    = issue;
      cmd.row_mask = sel[1] ? {1'b1, s2_rge1_ff, 1'b0} : {1'b1, 1'b1, s2_rge2_ff};
      cmd.col_mask = sel[0] ? {1'b1, s2_cge1_ff, 1'b0} : {1'b1, 1'b1, s2_cge2_ff};
      cmd.out_row  = row_ext[COORD_W-1:0];
      cmd.out_col  = col_ext[COORD_W-1:0];
      cmd.run_end  = (pend_rest == '0);
   end

   bb3_average u_average (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .win       (win_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   bb3_rsp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (res_valid),
      .wr_data  (res),
      .rd_en    (rsp_bus.ready),
      .rd_valid (rsp_bus.valid),
      .rd_data  (rsp_bus.payload)
   );

   // Credit counts results issued and not yet taken.
   assign pop = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      case ({issue, pop})
         2'b10:   credit_in = credit_ff + CREDIT_W'(1);
         2'b01:   credit_in = credit_ff - CREDIT_W'(1);
         default: credit_in = credit_ff;
      endcase
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (req_fire) begin
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
         s1_pix_ff <= {req_bus.payload.red_in, req_bus.payload.green_in,
                       req_bus.payload.blue_in};
      end
      if (s1_adv) begin
         s2_col_ff  <= s1_col_ff;
         s2_row_ff  <= s1_row_ff;
         s2_rge1_ff <= (s1_row_ff != '0);
         s2_rge2_ff <= (s1_row_ff > ROW_W'(1));
         s2_cge1_ff <= (s1_col_ff != '0);
         s2_cge2_ff <= (s1_col_ff > COL_W'(1));
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= COL_W'(W_RST);
         height_last_ff <= ROW_W'(H_RST);
         col_ff         <= '0;
         row_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         pend_ff        <= '0;
         credit_ff      <= '0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         s1_valid_ff    <= s1_valid_in;
         pend_ff        <= pend_in;
         credit_ff      <= credit_in;
      end
   end

endmodule

// ----- rtl/bb3_checker.sv -----
// Port-level checks of the 3x3 box blur, attached to the top level by bind.
// Depends on bb3_pkg and the macros in box_blur_3x3_edge_average_assert.svh.
`include "box_blur_3x3_edge_average_assert.svh"

module bb3_checker import bb3_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // A stalled result stays offered and unchanged.
   `BB3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // A result is withdrawn only after it was taken.
   `BB3_ASSERT_SAME(a_rsp_drop, clock, reset, $fell(rsp_valid) && !$past(reset), $past(rsp_ready))

   // Reset empties the result queue.
   `BB3_ASSERT_NEXT(a_rst_rsp_idle, clock, 1'b0, reset, !rsp_valid)

   // Reset leaves the block ready for a request.
   `BB3_ASSERT_NEXT(a_rst_req_open, clock, 1'b0, reset, req_ready)

endmodule

bind box_blur_3x3_edge_average bb3_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

// ----- tb/box_blur_3x3_edge_average_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3x3 box blur: a directed table, then random frames.
// Depends on bb3_pkg, bb3_if and the box_blur_3x3_edge_average top level.
module box_blur_3x3_edge_average_tb;
   import bb3_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_ITEMS  = 87;
   localparam int RUN_LIMIT_NS  = 2_000_000;
   localparam int SIDE_TX       = 0;
   localparam int SIDE_RX       = 1;

   // What a row of the directed table does and how its results are known.
   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_PIXEL,
      ROW_PIXEL_NONE,
      ROW_PIXEL_ONE
   } row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] reg_sel;
      logic [CFG_W-1:0]     reg_value;
      req_payload_type      px;
      rsp_payload_type      typed_rsp;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wr_data;

   bb3_req_if req_bus ();
   bb3_rsp_if rsp_bus ();

   box_blur_3x3_edge_average dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Blur predictor state: the three most recent rows, the frame position and the geometry.
   pixel_type        row_ring [3][MAX_WIDTH_DEF];
   int               pos_row    = 0;
   int               pos_col    = 0;
   logic [CFG_W-1:0] cfg_width  = CFG_W'(DIM_RESET);
   logic [CFG_W-1:0] cfg_height = CFG_W'(DIM_RESET);

   rsp_payload_type  step_blurs [$];
   rsp_payload_type  blur_expected [$];
   plan_row_type     plan [$];
   int               blur_errors = 0;
   int               calm_left [2] = '{0, 0};

   // A zero dimension acts as one, and an oversized one saturates.
   function automatic int eff_dim(input logic [CFG_W-1:0] value, input int limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return int'(value);
   endfunction

   // Truncated mean of the pixel at (i, j) and its in-frame neighbors.
   function automatic rsp_payload_type blur_at(input int i, input int j, input int w,
                                               input int h);
      int              y;
      int              x;
      int              ch;
      int              n;
      int              acc [NUM_CH];
      rsp_payload_type res;
      for (ch = 0; ch < NUM_CH; ch++) acc[ch] = 0;
      n = 0;
      for (y = i - 1; y <= i + 1; y++) begin
         for (x = j - 1; x <= j + 1; x++) begin
            if (y >= 0 && x >= 0 && y < h && x < w) begin
               for (ch = 0; ch < NUM_CH; ch++) acc[ch] += row_ring[y % 3][x][ch];
               n++;
            end
         end
      end
      res.out_row   = COORD_W'(i);
      res.out_col   = COORD_W'(j);
      res.red_out   = CH_W'(acc[CH_RED] / n);
      res.green_out = CH_W'(acc[CH_GREEN] / n);
      res.blue_out  = CH_W'(acc[CH_BLUE] / n);
      res.run_end   = 1'b0;
      return res;
   endfunction

   // Stores one accepted pixel and fills step_blurs with every output it completes.
   function automatic void blur_step(input req_payload_type px);
      int w;
      int h;
      int r;
      int c;
      int a;
      int b;
      int rows [$];
      int cols [$];
      w = eff_dim(cfg_width, MAX_WIDTH_DEF);
      h = eff_dim(cfg_height, MAX_HEIGHT_DEF);
      if (pos_row >= h || pos_col >= w) begin
         pos_row = 0;
         pos_col = 0;
      end
      r = pos_row;
      c = pos_col;
      row_ring[r % 3][c] = {px.red_in, px.green_in, px.blue_in};

      // The row above is complete once we pass its column; the last row also closes itself.
      if (r >= 1) rows.push_back(r - 1);
      if (r == h - 1) rows.push_back(r);
      if (c >= 1) cols.push_back(c - 1);
      if (c == w - 1) cols.push_back(c);

      step_blurs.delete();
      for (a = 0; a < rows.size(); a++) begin
         for (b = 0; b < cols.size(); b++) step_blurs.push_back(blur_at(rows[a], cols[b], w, h));
      end
      if (step_blurs.size() != 0) step_blurs[step_blurs.size() - 1].run_end = 1'b1;

      if (c + 1 >= w) begin
         pos_col = 0;
         pos_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         pos_col = c + 1;
      end
   endfunction

   // Idle length for either side: mostly none or short, a few long, and calm stretches.
   function automatic int pick_gap(input int side);
      int roll;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm_left[side] = $urandom_range(10, 40);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly small frames, with the zero, maximum and oversized settings now and then.
   function automatic logic [CFG_W-1:0] pick_dim(input int limit);
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 14) return CFG_W'($urandom_range(1, 6));
      if (roll < 16) return CFG_W'($urandom_range(7, 24));
      if (roll == 16) return '0;
      if (roll == 17) return CFG_W'(limit);
      if (roll == 18) return CFG_W'($urandom_range(limit + 1, 2047));
      return '1;
   endfunction

   function automatic logic [CH_W-1:0] rand_channel();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return CH_W'($urandom_range(0, 255));
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] sel,
                                     input logic [CFG_W-1:0] value);
      plan_row_type row;
      row.kind      = ROW_WRITE;
      row.reg_sel   = sel;
      row.reg_value = value;
      row.px        = '0;
      row.typed_rsp = '0;
      plan.push_back(row);
   endfunction

   function automatic void add_pixel(input row_kind_type kind, input logic [PIX_W-1:0] px,
                                     input rsp_payload_type typed_rsp);
      plan_row_type row;
      row.kind      = kind;
      row.reg_sel   = REG_FRAME_WIDTH;
      row.reg_value = '0;
      row.px        = px;
      row.typed_rsp = typed_rsp;
      plan.push_back(row);
   endfunction

   // Holds requests until every expected result is back and the pipe has gone quiet.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (blur_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register writes happen only with the block idle; each one restarts the frame.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] sel, input logic [CFG_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_index   <= sel;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (sel == REG_FRAME_WIDTH) begin
         cfg_width = value;
      end else begin
         cfg_height = value;
      end
      pos_row = 0;
      pos_col = 0;
      @(negedge clock);
   endtask

   // Sends one pixel request and records the results it should cause.
   task automatic send_pixel(input req_payload_type px, input row_kind_type kind,
                             input rsp_payload_type typed_rsp);
      int gap;
      gap = pick_gap(SIDE_TX);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= px;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      blur_step(px);
      case (kind)
         ROW_PIXEL_NONE: begin
            // The typed expectation is that nothing comes out yet.
         end
         ROW_PIXEL_ONE: begin
            blur_expected.push_back(typed_rsp);
         end
         default: begin
            foreach (step_blurs[n]) blur_expected.push_back(step_blurs[n]);
         end
      endcase
      @(negedge clock);
   endtask

   // Result side: random backpressure, driven on the falling edge.
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(SIDE_RX);
         end
      end
   end

   // Each accepted result is matched against the oldest expected blur.
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = rsp_bus.payload;
         if (blur_expected.size() == 0) begin
            if (blur_errors < REPORT_LIMIT)
               $display("%0t: unexpected result (%0d,%0d) rgb %h/%h/%h last %b", $realtime,
                        got.out_row, got.out_col, got.red_out, got.green_out, got.blue_out,
                        got.run_end);
            blur_errors++;
         end else begin
            want = blur_expected.pop_front();
            if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
                got.red_out !== want.red_out || got.green_out !== want.green_out ||
                got.blue_out !== want.blue_out || got.run_end !== want.run_end) begin
               if (blur_errors < REPORT_LIMIT)
                  $display("%0t: blur mismatch: want (%0d,%0d) rgb %h/%h/%h last %b, %s",
                           $realtime, want.out_row, want.out_col, want.red_out,
                           want.green_out, want.blue_out, want.run_end, "got");
               if (blur_errors < REPORT_LIMIT)
                  $display("   got (%0d,%0d) rgb %h/%h/%h last %b", got.out_row, got.out_col,
                           got.red_out, got.green_out, got.blue_out, got.run_end);
               blur_errors++;
            end
         end
      end
   end

   // Stimulus: directed table first, then random frames of random geometry.
   initial begin
      plan_row_type    row;
      req_payload_type px;
      int              k;
      int              j;
      int              random_items;
      int              phase;
      int              count;
      int              hold_at;
      int              frame;

      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = REG_FRAME_WIDTH;
      csr_wr_data     = '0;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Full-size frame after reset: the top row completes nothing.
      add_pixel(ROW_PIXEL_NONE, 24'hff0080, '0);
      add_pixel(ROW_PIXEL_NONE, 24'h123456, '0);
      // One-pixel frames: every request comes straight back as its own blur.
      add_write(REG_FRAME_WIDTH, 11'd1);
      add_write(REG_FRAME_HEIGHT, 11'd1);
      add_pixel(ROW_PIXEL_ONE, 24'hffffff, {10'd0, 10'd0, 24'hffffff, 1'b1});
      add_pixel(ROW_PIXEL_ONE, 24'h000000, {10'd0, 10'd0, 24'h000000, 1'b1});
      add_pixel(ROW_PIXEL_ONE, 24'ha55ac3, {10'd0, 10'd0, 24'ha55ac3, 1'b1});
      // Zero width and zero height behave as one.
      add_write(REG_FRAME_WIDTH, 11'd0);
      add_pixel(ROW_PIXEL_ONE, 24'h0180fe, {10'd0, 10'd0, 24'h0180fe, 1'b1});
      add_write(REG_FRAME_HEIGHT, 11'd0);
      add_pixel(ROW_PIXEL_ONE, 24'h7f8001, {10'd0, 10'd0, 24'h7f8001, 1'b1});
      // Oversized width saturates: a single long row, averaging pairs at the left edge.
      add_write(REG_FRAME_WIDTH, 11'd2047);
      add_pixel(ROW_PIXEL, 24'hffffff, '0);
      add_pixel(ROW_PIXEL, 24'h000001, '0);
      // Narrow frame with oversized height: only rows below the top produce blurs.
      add_write(REG_FRAME_WIDTH, 11'd3);
      add_write(REG_FRAME_HEIGHT, 11'd1025);
      add_pixel(ROW_PIXEL, 24'h102030, '0);
      add_pixel(ROW_PIXEL, 24'hf0e0d0, '0);
      add_pixel(ROW_PIXEL, 24'h8899aa, '0);
      add_pixel(ROW_PIXEL, 24'h000000, '0);
      add_pixel(ROW_PIXEL, 24'hffffff, '0);
      // A whole 3x3 frame: corners, edges and the center, with row and frame ends.
      add_write(REG_FRAME_HEIGHT, 11'd3);
      add_pixel(ROW_PIXEL, 24'hff0000, '0);
      add_pixel(ROW_PIXEL, 24'h00ff00, '0);
      add_pixel(ROW_PIXEL, 24'h0000ff, '0);
      add_pixel(ROW_PIXEL, 24'hffffff, '0);
      add_pixel(ROW_PIXEL, 24'h000000, '0);
      add_pixel(ROW_PIXEL, 24'h808080, '0);
      add_pixel(ROW_PIXEL, 24'h123456, '0);
      add_pixel(ROW_PIXEL, 24'hfedcba, '0);
      add_pixel(ROW_PIXEL, 24'h010203, '0);

      for (k = 0; k < plan.size(); k++) begin
         row = plan[k];
         if (row.kind == ROW_WRITE) begin
            write_reg(row.reg_sel, row.reg_value);
         end else begin
            send_pixel(row.px, row.kind, row.typed_rsp);
         end
      end

      // Random phases: mostly whole small frames, sometimes cut short by the next write.
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (phase == 0 || $urandom_range(0, 3) != 0)
            write_reg(REG_FRAME_WIDTH, pick_dim(MAX_WIDTH_DEF));
         if (phase == 0 || $urandom_range(0, 3) != 0)
            write_reg(REG_FRAME_HEIGHT, pick_dim(MAX_HEIGHT_DEF));
         frame = eff_dim(cfg_width, MAX_WIDTH_DEF) * eff_dim(cfg_height, MAX_HEIGHT_DEF);
         if (frame <= 48) begin
            count = frame * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, frame);
         end else begin
            count = $urandom_range(8, 40);
         end
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         hold_at = (phase == 0 || $urandom_range(0, 5) == 0) ? count / 2 : -1;
         for (j = 0; j < count; j++) begin
            // Let the block run dry in the middle of a frame.
            if (j == hold_at) wait_drained();
            px.red_in   = rand_channel();
            px.green_in = rand_channel();
            px.blue_in  = rand_channel();
            send_pixel(px, ROW_PIXEL, '0);
         end
         random_items += count;
         phase++;
      end

      wait_drained();
      if (blur_errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog against a hung handshake or results that never arrive.
   initial begin
      #RUN_LIMIT_NS;
      $display("FAILURE");
      $finish;
   end

endmodule
